// ----- rtl/spiral_order_matrix_reader_defines.svh -----
// Assertion macros shared by the spiral order matrix reader RTL.
// Plain text only; included by the files that carry assertions.
`ifndef SPIRAL_ORDER_MATRIX_READER_DEFINES_SVH
`define SPIRAL_ORDER_MATRIX_READER_DEFINES_SVH

// Property that must hold at every clock edge out of reset
`define SOR_ASSERT_NOW(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

// Same-cycle implication
`define SOR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define SOR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sor_pkg.sv -----
// Package for the spiral order matrix reader: command and register codes,
// walk directions and the packed words of both channels. No dependencies.
package sor_pkg;

    // Fixed field widths
    localparam int CMD_W      = 2;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD    = 2'd0,
        CMD_NEXT    = 2'd1,
        CMD_RESTART = 2'd2
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } t_reg_idx;

    // Direction of the current spiral pass, one-hot
    typedef enum logic [3:0] {
        DIR_RIGHT = 4'b0001,
        DIR_DOWN  = 4'b0010,
        DIR_LEFT  = 4'b0100,
        DIR_UP    = 4'b1000
    } t_dir;

    // Command word
    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] element_value;
    } t_cmd_word;

    // Result word
    typedef struct packed {
        logic signed [VALUE_W-1:0] spiral_value;
        logic [IDX_W-1:0]          row_index;
        logic [IDX_W-1:0]          column_index;
        logic                      last_of_spiral;
        logic                      exhausted;
    } t_result_word;

endpackage

// ----- rtl/sor_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sor_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/spiral_order_matrix_reader.sv -----
// Spiral order matrix reader: top level, walk logic and element store.
// Depends on sor_pkg, sor_ram and spiral_order_matrix_reader_defines.svh.
//
//  channel  | ports                              | handshake
//  ---------+------------------------------------+--------------------------------
//  command  | i_cmd_word                         | start high, busy low
//  result   | o_result                           | o_result_valid, one cycle only
//  config   | i_cfg_we, i_cfg_index, i_cfg_data  | i_cfg_we high, taken at once
//
// One command word per cycle; busy is never raised.
// A next command shows its result word in the cycle after it is taken: the
// element store has a registered read port and holds the only wait.
// Reset (synchronous) sets both counts to 16 and rewinds; the store is not cleared.
// A register write or a restart rewinds load pointer and spiral, stored words stay.
// The receiver cannot hold off a result word.
`include "spiral_order_matrix_reader_defines.svh"

module spiral_order_matrix_reader #(
    parameter int MAX_DIM = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  sor_pkg::t_cmd_word               i_cmd_word,
    output logic                             o_result_valid,
    output sor_pkg::t_result_word            o_result,
    input  logic                             i_cfg_we,
    input  logic [sor_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sor_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CO_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int BW    = DIM_W + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = CO_W + DIM_W;
    localparam logic signed [BW-1:0] ONE_S = BW'(1);

    // Clamp a count register to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [sor_pkg::CFG_DATA_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (32'(v) > MAX_DIM) begin
            res = DIM_W'(MAX_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // Clockwise turn
    function automatic sor_pkg::t_dir turn(input sor_pkg::t_dir d);
        sor_pkg::t_dir res;
        case (d)
            sor_pkg::DIR_RIGHT: res = sor_pkg::DIR_DOWN;
            sor_pkg::DIR_DOWN:  res = sor_pkg::DIR_LEFT;
            sor_pkg::DIR_LEFT:  res = sor_pkg::DIR_UP;
            default:            res = sor_pkg::DIR_RIGHT;
        endcase
        return res;
    endfunction

    // Configuration and walk state
    logic [sor_pkg::CFG_DATA_W-1:0] r_row_count, n_row_count;
    logic [sor_pkg::CFG_DATA_W-1:0] r_col_count, n_col_count;
    logic [CNT_W-1:0]               r_load_ptr, n_load_ptr;
    logic [CNT_W-1:0]               r_emitted, n_emitted;
    logic signed [BW-1:0]           r_top, n_top, r_bot, n_bot;
    logic signed [BW-1:0]           r_left, n_left, r_right, n_right;
    sor_pkg::t_dir                  r_dir, n_dir;
    logic [CO_W-1:0]                r_row, n_row, r_col, n_col;

    // Result register (value comes from the store read port)
    logic                           r_res_valid, n_res_valid;
    logic [CO_W-1:0]                r_res_row, n_res_row;
    logic [CO_W-1:0]                r_res_col, n_res_col;
    logic                           r_res_last, n_res_last;
    logic                           r_res_exh, n_res_exh;

    // Derived values
    logic [DIM_W-1:0]     eff_rows, eff_cols, new_rows, new_cols;
    logic [2*DIM_W-1:0]   total_prod;
    logic [CNT_W-1:0]     total;
    logic [PW-1:0]        rd_prod;
    logic [AW-1:0]        rd_addr;
    logic                 accept;
    logic                 rewind;
    logic                 ram_we;
    logic [sor_pkg::VALUE_W-1:0] ram_q;

    // Advance candidate
    logic signed [BW-1:0] a_top, a_bot, a_left, a_right;
    sor_pkg::t_dir        a_dir;
    logic [CO_W-1:0]      a_row, a_col;
    logic                 a_done;
    logic signed [BW-1:0] row_s, col_s;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign eff_rows   = clamp_dim(r_row_count);
    assign eff_cols   = clamp_dim(r_col_count);
    assign new_rows   = clamp_dim(n_row_count);
    assign new_cols   = clamp_dim(n_col_count);
    assign total_prod = eff_rows * eff_cols;
    assign total      = CNT_W'(total_prod);

    // Store address of the current spiral position
    assign rd_prod = r_row * eff_cols;
    assign rd_addr = AW'(rd_prod + PW'(r_col));

    assign row_s = signed'(BW'(r_row));
    assign col_s = signed'(BW'(r_col));

    // Count register writes
    always_comb begin
        n_row_count = r_row_count;
        n_col_count = r_col_count;
        if (i_cfg_we) begin
            case (i_cfg_index)
                sor_pkg::REG_ROW_COUNT:    n_row_count = i_cfg_data;
                sor_pkg::REG_COLUMN_COUNT: n_col_count = i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next spiral position: finish the current pass, then turn past empty passes
    always_comb begin
        a_top   = r_top;
        a_bot   = r_bot;
        a_left  = r_left;
        a_right = r_right;
        a_dir   = r_dir;
        a_row   = r_row;
        a_col   = r_col;
        a_done  = 1'b0;
        case (r_dir)
            sor_pkg::DIR_RIGHT: begin
                if (col_s < r_right) begin
                    a_col  = r_col + CO_W'(1);
                    a_done = 1'b1;
                end else begin
                    a_top = r_top + ONE_S;
                end
            end
            sor_pkg::DIR_DOWN: begin
                if (row_s < r_bot) begin
                    a_row  = r_row + CO_W'(1);
                    a_done = 1'b1;
                end else begin
                    a_right = r_right - ONE_S;
                end
            end
            sor_pkg::DIR_LEFT: begin
                if (col_s > r_left) begin
                    a_col  = r_col - CO_W'(1);
                    a_done = 1'b1;
                end else begin
                    a_bot = r_bot - ONE_S;
                end
            end
            sor_pkg::DIR_UP: begin
                if (row_s > r_top) begin
                    a_row  = r_row - CO_W'(1);
                    a_done = 1'b1;
                end else begin
                    a_left = r_left + ONE_S;
                end
            end
            default: a_done = 1'b1;
        endcase
        for (int k = 0; k < 4; k++) begin
            if (!a_done) begin
                a_dir = turn(a_dir);
                case (a_dir)
                    sor_pkg::DIR_RIGHT: begin
                        // spiral ends here when the bounds have crossed
                        a_done = 1'b1;
                        if (a_top <= a_bot && a_left <= a_right) begin
                            a_row = a_top[CO_W-1:0];
                            a_col = a_left[CO_W-1:0];
                        end
                    end
                    sor_pkg::DIR_DOWN: begin
                        if (a_top <= a_bot) begin
                            a_row  = a_top[CO_W-1:0];
                            a_col  = a_right[CO_W-1:0];
                            a_done = 1'b1;
                        end else begin
                            a_right = a_right - ONE_S;
                        end
                    end
                    sor_pkg::DIR_LEFT: begin
                        if (a_top <= a_bot) begin
                            if (a_right >= a_left) begin
                                a_row  = a_bot[CO_W-1:0];
                                a_col  = a_right[CO_W-1:0];
                                a_done = 1'b1;
                            end else begin
                                a_bot = a_bot - ONE_S;
                            end
                        end
                    end
                    sor_pkg::DIR_UP: begin
                        if (a_left <= a_right) begin
                            if (a_bot >= a_top) begin
                                a_row  = a_bot[CO_W-1:0];
                                a_col  = a_left[CO_W-1:0];
                                a_done = 1'b1;
                            end else begin
                                a_left = a_left + ONE_S;
                            end
                        end
                    end
                    default: a_done = 1'b1;
                endcase
            end
        end
    end

    // Command handling
    always_comb begin
        n_load_ptr  = r_load_ptr;
        n_emitted   = r_emitted;
        n_top       = r_top;
        n_bot       = r_bot;
        n_left      = r_left;
        n_right     = r_right;
        n_dir       = r_dir;
        n_row       = r_row;
        n_col       = r_col;
        n_res_valid = 1'b0;
        n_res_row   = r_res_row;
        n_res_col   = r_res_col;
        n_res_last  = r_res_last;
        n_res_exh   = r_res_exh;
        ram_we      = 1'b0;
        rewind      = 1'b0;
        if (i_cfg_we) begin
            rewind = 1'b1;
        end else if (accept) begin
            case (i_cmd_word.command)
                sor_pkg::CMD_LOAD: begin
                    if (r_load_ptr < total) begin
                        ram_we     = 1'b1;
                        n_load_ptr = r_load_ptr + CNT_W'(1);
                    end
                end
                sor_pkg::CMD_NEXT: begin
                    n_res_valid = 1'b1;
                    if (r_emitted >= total) begin
                        n_res_exh  = 1'b1;
                        n_res_row  = '0;
                        n_res_col  = '0;
                        n_res_last = 1'b0;
                    end else begin
                        n_res_exh  = 1'b0;
                        n_res_row  = r_row;
                        n_res_col  = r_col;
                        n_res_last = (r_emitted + CNT_W'(1)) == total;
                        n_emitted  = r_emitted + CNT_W'(1);
                        if (!n_res_last) begin
                            n_top   = a_top;
                            n_bot   = a_bot;
                            n_left  = a_left;
                            n_right = a_right;
                            n_dir   = a_dir;
                            n_row   = a_row;
                            n_col   = a_col;
                        end
                    end
                end
                sor_pkg::CMD_RESTART: rewind = 1'b1;
                default: ;
            endcase
        end
        if (rewind) begin
            n_load_ptr = '0;
            n_emitted  = '0;
            n_top      = '0;
            n_bot      = signed'(BW'(new_rows)) - ONE_S;
            n_left     = '0;
            n_right    = signed'(BW'(new_cols)) - ONE_S;
            n_dir      = sor_pkg::DIR_RIGHT;
            n_row      = '0;
            n_col      = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= sor_pkg::CFG_DATA_W'(16);
            r_col_count <= sor_pkg::CFG_DATA_W'(16);
            r_load_ptr  <= '0;
            r_emitted   <= '0;
            r_top       <= '0;
            r_bot       <= signed'(BW'(clamp_dim(sor_pkg::CFG_DATA_W'(16)))) - ONE_S;
            r_left      <= '0;
            r_right     <= signed'(BW'(clamp_dim(sor_pkg::CFG_DATA_W'(16)))) - ONE_S;
            r_dir       <= sor_pkg::DIR_RIGHT;
            r_row       <= '0;
            r_col       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_row_count <= n_row_count;
            r_col_count <= n_col_count;
            r_load_ptr  <= n_load_ptr;
            r_emitted   <= n_emitted;
            r_top       <= n_top;
            r_bot       <= n_bot;
            r_left      <= n_left;
            r_right     <= n_right;
            r_dir       <= n_dir;
            r_row       <= n_row;
            r_col       <= n_col;
            r_res_valid <= n_res_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_res_row  <= n_res_row;
        r_res_col  <= n_res_col;
        r_res_last <= n_res_last;
        r_res_exh  <= n_res_exh;
    end

    // Element store
    sor_ram #(
        .WIDTH (sor_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_ptr[AW-1:0]),
        .i_wdata (i_cmd_word.element_value),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Result word
    assign o_result_valid = r_res_valid;
    always_comb begin
        o_result.spiral_value   = r_res_exh ? '0 : signed'(ram_q);
        o_result.row_index      = sor_pkg::IDX_W'(r_res_row);
        o_result.column_index   = sor_pkg::IDX_W'(r_res_col);
        o_result.last_of_spiral = r_res_last;
        o_result.exhausted      = r_res_exh;
    end

    // Checks
    `SOR_ASSERT_NXT(a_next_gives_word, i_clk, i_rst_n,
        i_rst_n && accept && !i_cfg_we && i_cmd_word.command == sor_pkg::CMD_NEXT,
        o_result_valid, "next command gave no result word")
    `SOR_ASSERT_NXT(a_no_stray_word, i_clk, i_rst_n,
        !(accept && !i_cfg_we && i_cmd_word.command == sor_pkg::CMD_NEXT),
        !o_result_valid, "result word without a next command")
    `SOR_ASSERT_NOW(a_counts_in_range, i_clk, i_rst_n,
        r_load_ptr <= total && r_emitted <= total, "pointer beyond matrix size")
    `SOR_ASSERT_IMP(a_exhausted_clean, i_clk, i_rst_n,
        o_result_valid && o_result.exhausted,
        o_result.spiral_value == '0 && !o_result.last_of_spiral,
        "exhausted word carries data")
    `SOR_ASSERT_IMP(a_last_at_end, i_clk, i_rst_n,
        o_result_valid && o_result.last_of_spiral,
        r_emitted == total, "last flag before spiral end")

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for spiral_order_matrix_reader: directed table, then random phases.
// Holds its own spiral walk predictor and a shadow of the element store.
// Depends on sor_pkg and the RTL of the block only.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM        = 16;
    localparam int STORE_WORDS    = MAX_DIM * MAX_DIM;
    localparam int TOTAL_ITEMS    = 1150;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam int WATCHDOG_LIMIT = 300;

    // Command code the block ignores
    localparam logic [sor_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam sor_pkg::t_result_word NO_RES        = '0;
    localparam sor_pkg::t_result_word EXHAUSTED_RES = {32'h0, 4'd0, 4'd0, 1'b0, 1'b1};

    // One row of the directed table: either a shape change or a command word
    typedef struct {
        bit                    shape_change;
        logic [4:0]            rows_val;
        logic [4:0]            cols_val;
        sor_pkg::t_cmd_word    word;
        bit                    typed;
        sor_pkg::t_result_word want;
    } t_directed_row;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    sor_pkg::t_cmd_word    i_cmd_word  = '0;
    logic                  o_result_valid;
    sor_pkg::t_result_word o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [sor_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sor_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predictor state: shadow store, registers and spiral walk
    logic [sor_pkg::VALUE_W-1:0] shadow_store [STORE_WORDS];
    bit                          entry_loaded [STORE_WORDS];
    logic [4:0]                  row_reg = 5'd16;
    logic [4:0]                  col_reg = 5'd16;
    int                          load_ptr, emitted;
    int                          top_b, bottom_b, left_b, right_b, cur_row, cur_col;
    sor_pkg::t_dir               walk_dir;

    sor_pkg::t_result_word due_spiral_words [$];

    bit idle_stretch;
    int fails, words_sent, elements_seen, spirals_closed, exhausted_seen, shapes_tried;

    // Directed stimulus; typed expectations only where obvious
    t_directed_row directed_rows [] = '{
        // straight after reset: 16x16 in use
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'h7FFF_FFFF}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b1,
          {32'h7FFF_FFFF, 4'd0, 4'd0, 1'b0, 1'b0}},
        // 2x2: fill with extremes, overfill, unused code, full spiral, exhausted
        '{1'b1, 5'd2, 5'd2, {sor_pkg::CMD_RESTART, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'h8000_0000}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'hFFFF_FFFF}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'h0000_0001}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'h0000_0000}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'h1234_5678}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {CMD_UNUSED, 32'hFFFF_FFFF}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b1,
          {32'h8000_0000, 4'd0, 4'd0, 1'b0, 1'b0}},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b1, EXHAUSTED_RES},
        // restart keeps stored words, rewinds load pointer and walk
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_RESTART, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_LOAD, 32'h5A5A_5A5A}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_RESTART, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        // single row
        '{1'b1, 5'd1, 5'd3, {sor_pkg::CMD_RESTART, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b1, EXHAUSTED_RES},
        // single column
        '{1'b1, 5'd3, 5'd1, {sor_pkg::CMD_RESTART, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES},
        '{1'b0, 5'd0, 5'd0, {sor_pkg::CMD_NEXT, 32'h0}, 1'b0, NO_RES}
    };

    spiral_order_matrix_reader #(.MAX_DIM(MAX_DIM)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd_word     (i_cmd_word),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Register value as used: 0 reads as 1, anything above MAX_DIM as MAX_DIM
    function automatic int dim_in_use(logic [4:0] v);
        if (v == 5'd0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    function automatic int cells_in_use();
        return dim_in_use(row_reg) * dim_in_use(col_reg);
    endfunction

    function automatic sor_pkg::t_dir turn(sor_pkg::t_dir d);
        case (d)
            sor_pkg::DIR_RIGHT: return sor_pkg::DIR_DOWN;
            sor_pkg::DIR_DOWN:  return sor_pkg::DIR_LEFT;
            sor_pkg::DIR_LEFT:  return sor_pkg::DIR_UP;
            default:            return sor_pkg::DIR_RIGHT;
        endcase
    endfunction

    task automatic rewind();
        load_ptr = 0;
        top_b    = 0;
        bottom_b = dim_in_use(row_reg) - 1;
        left_b   = 0;
        right_b  = dim_in_use(col_reg) - 1;
        walk_dir = sor_pkg::DIR_RIGHT;
        cur_row  = 0;
        cur_col  = 0;
        emitted  = 0;
    endtask

    // Move to the next spiral position, passing over empty or crossed passes
    task automatic step_walk();
        int  k;
        bit  placed;
        placed = 1'b0;
        case (walk_dir)
            sor_pkg::DIR_RIGHT: if (cur_col < right_b) begin
                cur_col++; placed = 1'b1;
            end else top_b++;
            sor_pkg::DIR_DOWN: if (cur_row < bottom_b) begin
                cur_row++; placed = 1'b1;
            end else right_b--;
            sor_pkg::DIR_LEFT: if (cur_col > left_b) begin
                cur_col--; placed = 1'b1;
            end else bottom_b--;
            default: if (cur_row > top_b) begin
                cur_row--; placed = 1'b1;
            end else left_b++;
        endcase
        for (k = 0; k < 4 && !placed; k++) begin
            walk_dir = turn(walk_dir);
            case (walk_dir)
                sor_pkg::DIR_RIGHT: begin
                    // either a new ring starts or the spiral is over
                    if (top_b <= bottom_b && left_b <= right_b) begin
                        cur_row = top_b; cur_col = left_b;
                    end
                    placed = 1'b1;
                end
                sor_pkg::DIR_DOWN: if (top_b <= bottom_b) begin
                    cur_row = top_b; cur_col = right_b; placed = 1'b1;
                end else right_b--;
                sor_pkg::DIR_LEFT: if (top_b <= bottom_b) begin
                    if (right_b >= left_b) begin
                        cur_row = bottom_b; cur_col = right_b; placed = 1'b1;
                    end else bottom_b--;
                end
                default: if (left_b <= right_b) begin
                    if (bottom_b >= top_b) begin
                        cur_row = bottom_b; cur_col = left_b; placed = 1'b1;
                    end else left_b++;
                end
            endcase
        end
    endtask

    // Apply one accepted command word to the shadow state; return its result word
    task automatic predict_spiral_word(input sor_pkg::t_cmd_word w, output bit produces,
                                       output sor_pkg::t_result_word res);
        int cells;
        int addr;
        cells    = cells_in_use();
        produces = 1'b0;
        res      = NO_RES;
        case (w.command)
            sor_pkg::CMD_LOAD: if (load_ptr < cells) begin
                shadow_store[load_ptr] = w.element_value;
                entry_loaded[load_ptr] = 1'b1;
                load_ptr++;
            end
            sor_pkg::CMD_RESTART: rewind();
            sor_pkg::CMD_NEXT: begin
                produces = 1'b1;
                if (emitted >= cells) begin
                    res.exhausted = 1'b1;
                end else begin
                    addr               = cur_row * dim_in_use(col_reg) + cur_col;
                    res.spiral_value   = shadow_store[addr];
                    res.row_index      = 4'(cur_row);
                    res.column_index   = 4'(cur_col);
                    res.last_of_spiral = (emitted + 1 == cells);
                    emitted++;
                    if (emitted < cells) step_walk();
                end
            end
            default: ;
        endcase
    endtask

    // Random command word, weighted by where the walk stands
    function automatic sor_pkg::t_cmd_word pick_word();
        sor_pkg::t_cmd_word w;
        int unsigned        pick;
        int                 cells;
        bit                 big;
        cells           = cells_in_use();
        big             = cells > 32;
        pick            = $urandom_range(0, 99);
        w.element_value = $urandom();
        if (emitted >= cells) begin
            if (pick < 40)      w.command = sor_pkg::CMD_RESTART;
            else if (pick < 70) w.command = sor_pkg::CMD_NEXT;
            else if (pick < 90) w.command = sor_pkg::CMD_LOAD;
            else                w.command = CMD_UNUSED;
        end else if (load_ptr >= cells) begin
            if (pick < 85)              w.command = sor_pkg::CMD_NEXT;
            else if (pick < 93)         w.command = sor_pkg::CMD_LOAD;
            else if (pick < 96 && !big) w.command = sor_pkg::CMD_RESTART;
            else                        w.command = CMD_UNUSED;
        end else begin
            if (pick < 50)              w.command = sor_pkg::CMD_NEXT;
            else if (pick < 95)         w.command = sor_pkg::CMD_LOAD;
            else if (pick < 97 && !big) w.command = sor_pkg::CMD_RESTART;
            else                        w.command = CMD_UNUSED;
        end
        // never read an entry that was never written: load it first
        if (w.command == sor_pkg::CMD_NEXT && emitted < cells &&
            !entry_loaded[cur_row * dim_in_use(col_reg) + cur_col])
            w.command = sor_pkg::CMD_LOAD;
        return w;
    endfunction

    // Drive one command word, after a random gap unless idle_stretch is set, and wait for it to be taken
    task automatic send_word(input sor_pkg::t_cmd_word w, input bit typed,
                             input sor_pkg::t_result_word want);
        int                    gap;
        bit                    produces;
        sor_pkg::t_result_word res;
        gap = idle_stretch ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd_word <= w;
        do @(posedge i_clk); while (busy);
        predict_spiral_word(w, produces, res);
        if (produces)
            due_spiral_words.insert(due_spiral_words.size(), typed ? want : res);
        words_sent++;
    endtask

    // Write both count registers once the block has gone quiet
    task automatic set_shape(input logic [4:0] rows_val, input logic [4:0] cols_val);
        start <= 1'b0;
        while (due_spiral_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sor_pkg::REG_ROW_COUNT;
        i_cfg_data  <= rows_val;
        @(posedge i_clk);
        row_reg = rows_val;
        rewind();
        i_cfg_index <= sor_pkg::REG_COLUMN_COUNT;
        i_cfg_data  <= cols_val;
        @(posedge i_clk);
        col_reg = cols_val;
        rewind();
        i_cfg_we <= 1'b0;
        shapes_tried++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
            fails++;
        end
    endtask

    // Result words against the oldest expectation
    always @(posedge i_clk) begin : check_results
        sor_pkg::t_result_word want;
        if (i_rst_n && o_result_valid) begin
            if (due_spiral_words.size() == 0) begin
                $error("result word with nothing expected: 0x%011h", o_result);
                fails++;
            end else begin
                want = due_spiral_words.pop_front();
                check_field("spiral_value", want.spiral_value, o_result.spiral_value);
                check_field("row_index", want.row_index, o_result.row_index);
                check_field("column_index", want.column_index, o_result.column_index);
                check_field("last_of_spiral", want.last_of_spiral, o_result.last_of_spiral);
                check_field("exhausted", want.exhausted, o_result.exhausted);
                if (o_result.exhausted) exhausted_seen++;
                else elements_seen++;
                if (o_result.last_of_spiral) spirals_closed++;
            end
        end
    end

    // Watchdog: ends the run after too long without any handshake
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_result_valid || i_cfg_we) quiet = 0;
            else quiet++;
        end
        $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        logic [4:0]         fixed_rows [4] = '{5'd31, 5'd1, 5'd16, 5'd0};
        logic [4:0]         fixed_cols [4] = '{5'd17, 5'd16, 5'd1, 5'd0};
        logic [4:0]         rows_val, cols_val;
        sor_pkg::t_cmd_word w;
        int                 phase, budget, n;
        bit                 counts;

        rewind();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        idle_stretch = 1'b0;
        foreach (directed_rows[i]) begin
            if (directed_rows[i].shape_change)
                set_shape(directed_rows[i].rows_val, directed_rows[i].cols_val);
            else
                send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: clamped and edge shapes first, then mostly small shapes
        phase = 0;
        while (words_sent < TOTAL_ITEMS) begin
            if (phase < 4) begin
                rows_val = fixed_rows[phase];
                cols_val = fixed_cols[phase];
            end else begin
                rows_val = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 6))
                                                      : 5'($urandom_range(0, 31));
                cols_val = ($urandom_range(0, 9) < 8) ? 5'($urandom_range(1, 6))
                                                      : 5'($urandom_range(0, 31));
            end
            set_shape(rows_val, cols_val);
            idle_stretch = ($urandom_range(0, 9) < 3);
            budget       = 2 * cells_in_use() + $urandom_range(8, 24);
            n            = 0;
            while (n < budget && words_sent < TOTAL_ITEMS) begin
                w      = pick_word();
                // ignored words do not count towards the shape's budget
                counts = !(w.command == CMD_UNUSED ||
                           (w.command == sor_pkg::CMD_LOAD && load_ptr >= cells_in_use()));
                send_word(w, 1'b0, NO_RES);
                if (counts) n++;
            end
            phase++;
        end

        // Drain and finish
        start <= 1'b0;
        while (due_spiral_words.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Run sent %0d command words over %0d matrix shapes, 1x1 up to 16x16.",
                 words_sent, shapes_tried);
        $display("Checked %0d spiral elements, %0d completed spirals, %0d exhausted replies.",
                 elements_seen, spirals_closed, exhausted_seen);
        if (fails == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sor_pkg.sv
rtl/sor_ram.sv
rtl/spiral_order_matrix_reader.sv
verif/tb_top.sv
